>>> design/mmbd_pkg.sv
// ----------------------------------------------------------------------------
// mmbd_pkg
// Shared constants and types for the 2x2 box filter mipmap downsampler.
// ----------------------------------------------------------------------------
package mmbd_pkg;

    localparam int MAX_DEST_WIDTH  = 2048;
    localparam int MAX_DEST_HEIGHT = 4096;

    // Register field widths.
    localparam int DW_W = 12;
    localparam int DH_W = 13;

    // Source position counters and line store addressing.
    localparam int COL_W  = $clog2(2 * MAX_DEST_WIDTH);
    localparam int ROW_W  = $clog2(2 * MAX_DEST_HEIGHT);
    localparam int SLOT_W = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;

    // Pixel layout: four 8-bit channels, pair sums carry one extra bit each.
    localparam int LANES  = 4;
    localparam int CH_W   = 8;
    localparam int PSUM_W = CH_W + 1;
    localparam int PIX_W  = LANES * CH_W;
    localparam int LSUM_W = LANES * PSUM_W;

    // Register indexes on the configuration port.
    localparam int REG_DEST_WIDTH  = 0;
    localparam int REG_DEST_HEIGHT = 1;

    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [LSUM_W-1:0] t_lsum;

    // Request to the line store.
    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        t_slot addr;
        t_lsum wdata;
    } t_ls_req;

endpackage

>>> design/mipmap_box_downsample.sv
// ----------------------------------------------------------------------------
// mipmap_box_downsample
// 2x2 box filter that builds one RGBA8 mipmap level from a raster stream.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ------------------------------
//  input     in         i_in_valid/o_in_stall  i_src_pixel
//  output    out        o_out_valid/i_out_stall o_out_pixel, o_level_done
//  config    in         APB (psel, penable)    paddr, pwdata / prdata
//
//  One source pixel is taken every cycle unless stalled; a result appears in
//  the output register in the cycle after the second pixel of an odd-row pair.
//  The single output register decides the rate: the input stalls only while
//  a result sits in it and the output side stalls.
//  Reset is synchronous and active low; it clears the position, the
//  dimensions and the output valid flag. The line store is not cleared.
//  A register write restarts the level at row 0, column 0.
//
// ----------------------------------------------------------------------------
module mipmap_box_downsample (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Source pixel stream.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [mmbd_pkg::PIX_W-1:0]   i_src_pixel,
    // Downsampled pixel stream.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [mmbd_pkg::PIX_W-1:0]   o_out_pixel,
    output logic                         o_level_done,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import mmbd_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. The last source column and row are derived
    // at write time so the datapath only compares against a register.
    // ------------------------------------------------------------------
    logic [DW_W-1:0] r_dest_width;
    logic [DH_W-1:0] r_dest_height;
    t_col            r_last_col;
    t_row            r_last_row;

    logic            w_cfg_wr;
    logic            w_cfg_sel_h;
    logic [DW_W-1:0] w_wr_w;
    logic [DH_W-1:0] w_wr_h;
    logic [DW_W-1:0] w_clamp_w;
    logic [DH_W-1:0] w_clamp_h;
    logic [DW_W-1:0] w_wm1;
    logic [DH_W-1:0] w_hm1;

    assign pready      = 1'b1;
    assign w_cfg_wr    = psel & penable & pwrite & pready;
    assign w_cfg_sel_h = (paddr[2] == 1'(REG_DEST_HEIGHT));
    assign w_wr_w      = pwdata[DW_W-1:0];
    assign w_wr_h      = pwdata[DH_W-1:0];

    // A zero dimension counts as one; oversized values saturate.
    always_comb begin
        if (w_wr_w == '0) begin
            w_clamp_w = DW_W'(1);
        end else if ({1'b0, w_wr_w} > (DW_W+1)'(MAX_DEST_WIDTH)) begin
            w_clamp_w = DW_W'(MAX_DEST_WIDTH);
        end else begin
            w_clamp_w = w_wr_w;
        end
        if (w_wr_h == '0) begin
            w_clamp_h = DH_W'(1);
        end else if ({1'b0, w_wr_h} > (DH_W+1)'(MAX_DEST_HEIGHT)) begin
            w_clamp_h = DH_W'(MAX_DEST_HEIGHT);
        end else begin
            w_clamp_h = w_wr_h;
        end
    end

    // Last index of a source line is 2 * dim - 1, i.e. (dim - 1) shifted
    // left with a one shifted in.
    assign w_wm1 = w_clamp_w - DW_W'(1);
    assign w_hm1 = w_clamp_h - DH_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_width  <= DW_W'(1);
            r_dest_height <= DH_W'(1);
            r_last_col    <= COL_W'(1);
            r_last_row    <= ROW_W'(1);
        end else if (w_cfg_wr) begin
            if (w_cfg_sel_h) begin
                r_dest_height <= w_wr_h;
                r_last_row    <= {w_hm1[ROW_W-2:0], 1'b1};
            end else begin
                r_dest_width  <= w_wr_w;
                r_last_col    <= {w_wm1[COL_W-2:0], 1'b1};
            end
        end
    end

    always_comb begin
        if (w_cfg_sel_h) begin
            prdata = 32'(r_dest_height);
        end else begin
            prdata = 32'(r_dest_width);
        end
    end

    // ------------------------------------------------------------------
    // Source position and input handshake. The input is held off only
    // when the output register is full and cannot drain this cycle.
    // ------------------------------------------------------------------
    t_col             r_col;
    t_row             r_row;
    logic [PIX_W-1:0] r_pair_hold;
    logic             r_out_valid;
    logic             w_in_xfer;
    logic             w_produce;
    logic             w_end_col;
    logic             w_end_row;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_in_xfer  = i_in_valid & ~o_in_stall;
    assign w_end_col  = (r_col == r_last_col);
    assign w_end_row  = (r_row == r_last_row);
    assign w_produce  = w_in_xfer & r_col[0] & r_row[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_in_xfer) begin
            if (w_end_col) begin
                r_col <= '0;
                r_row <= w_end_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // First pixel of each pair is held until its partner arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_hold <= '0;
        end else if (w_cfg_wr) begin
            r_pair_hold <= '0;
        end else if (w_in_xfer && !r_col[0]) begin
            r_pair_hold <= i_src_pixel;
        end
    end

    // ------------------------------------------------------------------
    // Per-channel lanes. Each lane forms the horizontal pair sum and the
    // four-sample mean against the sum stored from the even row above.
    // ------------------------------------------------------------------
    t_lsum            w_pair_sum;
    t_lsum            w_above;
    logic [PIX_W-1:0] w_avg;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mmbd_lane u_lane (
            .i_hold_ch (r_pair_hold[g*CH_W +: CH_W]),
            .i_cur_ch  (i_src_pixel[g*CH_W +: CH_W]),
            .i_above   (w_above[g*PSUM_W +: PSUM_W]),
            .o_pair    (w_pair_sum[g*PSUM_W +: PSUM_W]),
            .o_avg     (w_avg[g*CH_W +: CH_W])
        );
    end

    // ------------------------------------------------------------------
    // Line store. Even rows write the pair sum on the second pixel of a
    // pair. Odd rows read on the first pixel of the pair; the registered
    // read data then waits for the second pixel, however late it comes,
    // since odd rows never write.
    // ------------------------------------------------------------------
    t_ls_req w_ls_req;

    always_comb begin
        w_ls_req.wr_en = w_in_xfer & r_col[0] & ~r_row[0];
        w_ls_req.rd_en = w_in_xfer & ~r_col[0] & r_row[0];
        w_ls_req.addr  = r_col[COL_W-1:1];
        w_ls_req.wdata = w_pair_sum;
    end

    mmbd_line_store u_line_store (
        .i_clk   (i_clk),
        .i_req   (w_ls_req),
        .o_rdata (w_above)
    );

    // ------------------------------------------------------------------
    // Merge stage: lane results are packed into the output register. It
    // is reloaded whenever a result is made, which the stall logic only
    // allows when it is empty or being taken in the same cycle.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_produce) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_out_pixel <= w_avg;
            r_out_done  <= w_end_col & w_end_row;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_pixel  = r_out_pixel;
    assign o_level_done = r_out_done;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The column never runs past the end of a source line.
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_last_col)
        else $error("source column beyond last column");

    // The last pixel of a level wraps the position back to the origin.
    a_level_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && !w_cfg_wr && w_end_col && w_end_row) |=>
        (r_col == '0 && r_row == '0))
        else $error("position did not wrap at end of level");

    // A result made on a transfer is presented on the next cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_produce |=> r_out_valid)
        else $error("result lost before the output register");

    // A line store read happens only on odd rows, a write only on even rows.
    a_ls_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ls_req.wr_en |-> !r_row[0]) and (w_ls_req.rd_en |-> r_row[0]))
        else $error("line store access on the wrong row");

endmodule

>>> design/mmbd_lane.sv
// ----------------------------------------------------------------------------
// mmbd_lane
// One byte channel: horizontal pair sum and the floor of the 2x2 mean.
// ----------------------------------------------------------------------------
module mmbd_lane (
    input  logic [mmbd_pkg::CH_W-1:0]   i_hold_ch,
    input  logic [mmbd_pkg::CH_W-1:0]   i_cur_ch,
    input  logic [mmbd_pkg::PSUM_W-1:0] i_above,
    output logic [mmbd_pkg::PSUM_W-1:0] o_pair,
    output logic [mmbd_pkg::CH_W-1:0]   o_avg
);
    import mmbd_pkg::*;

    logic [PSUM_W:0] w_quad;

    assign o_pair = {1'b0, i_hold_ch} + {1'b0, i_cur_ch};
    assign w_quad = {1'b0, i_above} + {1'b0, o_pair};
    // Divide by four, truncating.
    assign o_avg  = w_quad[PSUM_W:2];

endmodule

>>> design/mmbd_line_store.sv
// ----------------------------------------------------------------------------
// mmbd_line_store
// One-port line store holding the pair sums of the last even source row.
// ----------------------------------------------------------------------------
module mmbd_line_store (
    input  logic             i_clk,
    input  mmbd_pkg::t_ls_req i_req,
    output mmbd_pkg::t_lsum  o_rdata
);
    import mmbd_pkg::*;

    t_lsum r_mem [MAX_DEST_WIDTH];
    t_lsum r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
